/* rtl/pbsd_pkg.sv */
// Package with shared types and constants of the pitch-bend string decoder.
`timescale 1ns / 1ps

package pbsd_pkg;

  localparam int BEND_CAPACITY_DEF = 16384;

  localparam int ValW   = 12;
  localparam int IdxW   = 15;
  localparam int AccW   = 24;
  localparam int LenW   = 4;

  localparam logic [LenW-1:0] LEN_SAT = 4'd8;

  localparam logic [7:0] CH_HASH  = 8'h23;
  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_SLASH = 8'h2F;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_UP_A  = 8'h41;
  localparam logic [7:0] CH_UP_Z  = 8'h5A;
  localparam logic [7:0] CH_LO_A  = 8'h61;
  localparam logic [7:0] CH_LO_Z  = 8'h7A;
  localparam logic [7:0] CH_DIG_0 = 8'h30;
  localparam logic [7:0] CH_DIG_9 = 8'h39;

  localparam logic [7:0] SXT_LO_BASE  = 8'd26;
  localparam logic [7:0] SXT_DIG_BASE = 8'd52;
  localparam logic [5:0] SXT_PLUS     = 6'd62;
  localparam logic [5:0] SXT_SLASH    = 6'd63;

  typedef enum logic [3:0] {
    PH_IDLE = 4'b0001,
    PH_HALF = 4'b0010,
    PH_LEAD = 4'b0100,
    PH_NUM  = 4'b1000
  } phase_t;

  typedef struct packed {
    logic [5:0] sextet;
    logic [3:0] digit;
    logic       is_hash;
    logic       is_plus;
    logic       is_blank;
    logic       is_digit;
  } char_class_t;

  typedef struct packed {
    logic [ValW-1:0] sample_value;
    logic [IdxW-1:0] start_index;
    logic [IdxW-1:0] run_count;
    logic            is_final;
    logic [IdxW-1:0] total_count;
  } rec_t;

endpackage

/* rtl/pbsd_char_decode.sv */
// Character classifier: base64 sextet, digit value and character classes.
`timescale 1ns / 1ps

module pbsd_char_decode (
  input  logic [7:0]                 char_code,
  output pbsd_pkg::char_class_t      cls
);

  logic [7:0] diff;

  always_comb begin
    diff = 8'd0;
    cls = '0;
    if (char_code >= pbsd_pkg::CH_UP_A && char_code <= pbsd_pkg::CH_UP_Z) begin
      diff = char_code - pbsd_pkg::CH_UP_A;
    end else if (char_code >= pbsd_pkg::CH_LO_A && char_code <= pbsd_pkg::CH_LO_Z) begin
      diff = char_code - pbsd_pkg::CH_LO_A + pbsd_pkg::SXT_LO_BASE;
    end else if (char_code >= pbsd_pkg::CH_DIG_0 && char_code <= pbsd_pkg::CH_DIG_9) begin
      diff = char_code - pbsd_pkg::CH_DIG_0 + pbsd_pkg::SXT_DIG_BASE;
    end else if (char_code == pbsd_pkg::CH_PLUS) begin
      diff = {2'b00, pbsd_pkg::SXT_PLUS};
    end else if (char_code == pbsd_pkg::CH_SLASH) begin
      diff = {2'b00, pbsd_pkg::SXT_SLASH};
    end
    cls.sextet   = diff[5:0];
    cls.is_digit = (char_code >= pbsd_pkg::CH_DIG_0) && (char_code <= pbsd_pkg::CH_DIG_9);
    cls.digit    = 4'(char_code - pbsd_pkg::CH_DIG_0);
    cls.is_hash  = (char_code == pbsd_pkg::CH_HASH);
    cls.is_plus  = (char_code == pbsd_pkg::CH_PLUS);
    cls.is_blank = (char_code == pbsd_pkg::CH_SPACE) ||
                   ((char_code >= pbsd_pkg::CH_TAB) && (char_code <= pbsd_pkg::CH_CR));
  end

endmodule

/* rtl/pbsd_parser.sv */
// Parse state, repeat-count accumulation and record formation for one character.
`timescale 1ns / 1ps

module pbsd_parser #(
  parameter int BEND_CAPACITY = pbsd_pkg::BEND_CAPACITY_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  step,
  input  logic                  string_end,
  input  pbsd_pkg::char_class_t cls,
  output logic                  rec_valid,
  output pbsd_pkg::rec_t        rec
);

  localparam int PosW = $clog2(BEND_CAPACITY + 1);
  localparam int CmpW = (PosW > pbsd_pkg::AccW) ? PosW : pbsd_pkg::AccW;
  localparam int ExtW = (PosW > pbsd_pkg::IdxW) ? PosW : pbsd_pkg::IdxW;
  localparam logic [PosW-1:0] CapW = PosW'(BEND_CAPACITY);

  pbsd_pkg::phase_t              phase_r, phase_nxt;
  logic [5:0]                    first_r, first_nxt;
  logic [pbsd_pkg::ValW-1:0]     held_r, held_nxt;
  logic [pbsd_pkg::AccW-1:0]     acc_r, acc_nxt;
  logic [pbsd_pkg::LenW-1:0]     len_r, len_nxt;
  logic                          stop_r, stop_nxt;
  logic [PosW-1:0]               pos_r, pos_nxt;

  logic                          emit;
  logic                          has_room;
  logic [PosW-1:0]               room;
  logic [pbsd_pkg::AccW-1:0]     cnt;
  logic [PosW-1:0]               rcount;
  logic [ExtW-1:0]               start_ext, count_ext, total_ext;

  always_comb begin
    phase_nxt = phase_r;
    first_nxt = first_r;
    held_nxt  = held_r;
    acc_nxt   = acc_r;
    len_nxt   = len_r;
    stop_nxt  = stop_r;
    pos_nxt   = pos_r;
    emit      = 1'b0;
    rcount    = '0;
    has_room  = (pos_r < CapW);
    room      = CapW - pos_r;
    cnt       = (len_r < pbsd_pkg::LEN_SAT) ? acc_r : '0;

    unique case (phase_r)
      pbsd_pkg::PH_IDLE: begin
        if (cls.is_hash) begin
          phase_nxt = pbsd_pkg::PH_LEAD;
          acc_nxt   = '0;
          len_nxt   = '0;
          stop_nxt  = 1'b0;
        end else begin
          first_nxt = cls.sextet;
          phase_nxt = pbsd_pkg::PH_HALF;
        end
      end
      pbsd_pkg::PH_HALF: begin
        held_nxt  = {first_r, cls.sextet};
        emit      = 1'b1;
        rcount    = has_room ? PosW'(1) : '0;
        pos_nxt   = pos_r + rcount;
        phase_nxt = pbsd_pkg::PH_IDLE;
      end
      pbsd_pkg::PH_LEAD, pbsd_pkg::PH_NUM: begin
        if (cls.is_hash) begin
          if (has_room) begin
            emit    = 1'b1;
            rcount  = (CmpW'(cnt) < CmpW'(room)) ? PosW'(cnt) : room;
            pos_nxt = pos_r + rcount;
          end
          phase_nxt = pbsd_pkg::PH_IDLE;
        end else begin
          if (len_r < pbsd_pkg::LEN_SAT) begin
            len_nxt = len_r + pbsd_pkg::LenW'(1);
          end
          if (phase_r == pbsd_pkg::PH_LEAD) begin
            if (cls.is_blank) begin
              phase_nxt = pbsd_pkg::PH_LEAD;
            end else if (cls.is_plus) begin
              phase_nxt = pbsd_pkg::PH_NUM;
            end else if (cls.is_digit) begin
              acc_nxt   = pbsd_pkg::AccW'(cls.digit);
              phase_nxt = pbsd_pkg::PH_NUM;
            end else begin
              acc_nxt   = '0;
              stop_nxt  = 1'b1;
              phase_nxt = pbsd_pkg::PH_NUM;
            end
          end else if (!stop_r && cls.is_digit && (len_nxt < pbsd_pkg::LEN_SAT)) begin
            acc_nxt = {acc_r[pbsd_pkg::AccW-4:0], 3'b000} +
                      {acc_r[pbsd_pkg::AccW-2:0], 1'b0} +
                      pbsd_pkg::AccW'(cls.digit);
          end else begin
            stop_nxt = 1'b1;
          end
        end
      end
      default: begin
        phase_nxt = pbsd_pkg::PH_IDLE;
      end
    endcase

    start_ext = ExtW'(pos_r);
    count_ext = ExtW'(rcount);
    total_ext = string_end ? ExtW'(pos_nxt) : '0;

    rec_valid        = emit || string_end;
    rec.sample_value = held_nxt;
    rec.start_index  = start_ext[pbsd_pkg::IdxW-1:0];
    rec.run_count    = count_ext[pbsd_pkg::IdxW-1:0];
    rec.is_final     = string_end;
    rec.total_count  = total_ext[pbsd_pkg::IdxW-1:0];

    if (string_end) begin
      phase_nxt = pbsd_pkg::PH_IDLE;
      first_nxt = '0;
      held_nxt  = '0;
      acc_nxt   = '0;
      len_nxt   = '0;
      stop_nxt  = 1'b0;
      pos_nxt   = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= pbsd_pkg::PH_IDLE;
      first_r <= '0;
      held_r  <= '0;
      acc_r   <= '0;
      len_r   <= '0;
      stop_r  <= 1'b0;
      pos_r   <= '0;
    end else if (step) begin
      phase_r <= phase_nxt;
      first_r <= first_nxt;
      held_r  <= held_nxt;
      acc_r   <= acc_nxt;
      len_r   <= len_nxt;
      stop_r  <= stop_nxt;
      pos_r   <= pos_nxt;
    end
  end

endmodule

/* rtl/pitch_bend_string_decoder_unit.sv */
// Top level of the pitch-bend string decoder: input register, parser and result register.
//
//   Channel | Handshake            | Fields (after the channel prefix)
//   in      | in_valid, in_ready   | char_code, string_end
//   out     | out_valid, out_ready | sample_value, start_index, run_count, is_final, total_count
//
// One character per cycle while in_ready is high; records pass the input and result registers.
// The parse state updates in the same cycle the held character moves toward the result register.
// Reset is synchronous and active low and returns the parser to the start of a string.
// A stalled result register holds the input register, which then lowers in_ready.
`timescale 1ns / 1ps

module pitch_bend_string_decoder_unit #(
  parameter int BEND_CAPACITY = pbsd_pkg::BEND_CAPACITY_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic [7:0]                        in_char_code,
  input  logic                              in_string_end,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic signed [pbsd_pkg::ValW-1:0]  out_sample_value,
  output logic [pbsd_pkg::IdxW-1:0]         out_start_index,
  output logic [pbsd_pkg::IdxW-1:0]         out_run_count,
  output logic                              out_is_final,
  output logic [pbsd_pkg::IdxW-1:0]         out_total_count
);

  logic                  s1_valid_r;
  logic [7:0]            s1_char_r;
  logic                  s1_end_r;
  logic                  out_valid_r;
  pbsd_pkg::rec_t        out_rec_r;

  logic                  adv;
  logic                  step;
  logic                  rec_valid;
  pbsd_pkg::rec_t        rec;
  pbsd_pkg::char_class_t cls;

  assign adv      = !out_valid_r || out_ready;
  assign in_ready = !s1_valid_r || adv;
  assign step     = s1_valid_r && adv;

  pbsd_char_decode u_decode (
    .char_code (s1_char_r),
    .cls       (cls)
  );

  pbsd_parser #(
    .BEND_CAPACITY (BEND_CAPACITY)
  ) u_parser (
    .clk        (clk),
    .rst_n      (rst_n),
    .step       (step),
    .string_end (s1_end_r),
    .cls        (cls),
    .rec_valid  (rec_valid),
    .rec        (rec)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_ready) begin
      s1_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      s1_char_r <= in_char_code;
      s1_end_r  <= in_string_end;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv) begin
      out_valid_r <= step && rec_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (step && rec_valid) begin
      out_rec_r <= rec;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_sample_value = $signed(out_rec_r.sample_value);
  assign out_start_index  = out_rec_r.start_index;
  assign out_run_count    = out_rec_r.run_count;
  assign out_is_final     = out_rec_r.is_final;
  assign out_total_count  = out_rec_r.total_count;

  a_total_only_final: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_is_final |-> out_total_count == '0)
    else $error("Total count is nonzero on a record that is not final.");

  a_stall_holds_input: assert property (@(posedge clk) disable iff (!rst_n)
    s1_valid_r && !adv |=> s1_valid_r && $stable(s1_char_r) && $stable(s1_end_r))
    else $error("Held character changed while the result register was stalled.");

  a_ready_low_cause: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready |-> s1_valid_r && out_valid_r && !out_ready)
    else $error("Input was refused without a full pipeline and a stalled output.");

endmodule
